// ----- hdl/mhb_pkg.sv -----
// Shared constants, state encoding and controller/datapath interface types for the heap builder.
`default_nettype none

package mhb_pkg;

    localparam int DEPTH  = 64;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = ADDR_W + 1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_NEXT,
        ST_KEY,
        ST_LEFT,
        ST_RIGHT,
        ST_CMP,
        ST_FINAL,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic next_parent;
        logic take_key;
        logic take_left;
        logic take_right;
        logic step_down;
        logic put_key;
        logic out_clear;
        logic out_read;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic i_zero;
        logic c_lt_n;
        logic right_ok;
        logic best_lt_key;
        logic newc_lt_n;
        logic out_free;
        logic out_last;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/mhb_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/mhb_ctrl.sv -----
// Sequencer for load, bottom-up sift-down build and level-order readout.
`default_nettype none

module mhb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    output mhb_pkg::cmd_t      cmd,
    input  wire mhb_pkg::sts_t sts
);

    import mhb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                if (sts.i_zero)
                begin
                    cmd.out_clear = 1'b1;
                    state_next    = ST_OUT_RD;
                end
                else
                begin
                    cmd.next_parent = 1'b1;
                    state_next      = ST_KEY;
                end
            end
            ST_KEY:
            begin
                cmd.take_key = 1'b1;
                // leaf parent: nothing to sift, key already in place
                state_next = sts.c_lt_n ? ST_LEFT : ST_NEXT;
            end
            ST_LEFT:
            begin
                cmd.take_left = 1'b1;
                state_next    = sts.right_ok ? ST_RIGHT : ST_CMP;
            end
            ST_RIGHT:
            begin
                cmd.take_right = 1'b1;
                state_next     = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.best_lt_key)
                begin
                    cmd.step_down = 1'b1;
                    state_next    = sts.newc_lt_n ? ST_LEFT : ST_FINAL;
                end
                else
                begin
                    cmd.put_key = 1'b1;
                    state_next  = ST_NEXT;
                end
            end
            ST_FINAL:
            begin
                cmd.put_key = 1'b1;
                state_next  = ST_NEXT;
            end
            ST_OUT_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_OUT_LD;
                end
            end
            ST_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = sts.out_last ? ST_LOAD : ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/mhb_dp.sv -----
// Datapath: key store, element count, sift-down registers, comparators and output register.
`default_nettype none

module mhb_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mhb_pkg::cmd_t               cmd,
    output mhb_pkg::sts_t                    sts,
    input  wire logic [mhb_pkg::KEY_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [mhb_pkg::KEY_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    import mhb_pkg::*;

    logic [CNT_W-1:0]         cnt_reg,   cnt_next;
    logic [CNT_W-1:0]         n_reg,     n_next;
    logic [ADDR_W-1:0]        i_reg,     i_next;
    logic [ADDR_W-1:0]        o_reg,     o_next;
    logic                     mvalid_reg, mvalid_next;
    logic [ADDR_W-1:0]        p_reg,     p_next;
    logic [ADDR_W-1:0]        c_reg,     c_next;
    logic [ADDR_W-1:0]        bc_reg,    bc_next;
    logic signed [KEY_W-1:0]  key_reg,   key_next;
    logic signed [KEY_W-1:0]  best_reg,  best_next;
    logic [KEY_W-1:0]         mdata_reg, mdata_next;
    logic                     mlast_reg, mlast_next;

    logic [CNT_W-1:0]         n_fill;
    logic [CNT_W-1:0]         child_idx;
    logic [CNT_W-1:0]         right_idx;
    logic [CNT_W-1:0]         newc_idx;
    logic                     room;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [KEY_W-1:0]         wdata;
    logic [ADDR_W-1:0]        raddr;
    logic [KEY_W-1:0]         rdata;
    logic signed [KEY_W-1:0]  rkey;

    mhb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rkey      = signed'(rdata);
    assign room      = (cnt_reg < CNT_W'(DEPTH));
    assign n_fill    = room ? (cnt_reg + CNT_W'(1)) : cnt_reg;
    assign child_idx = {p_reg, 1'b1};
    assign right_idx = {1'b0, c_reg} + CNT_W'(1);
    assign newc_idx  = {bc_reg, 1'b1};

    always_comb
    begin
        sts.i_zero      = (i_reg == '0);
        sts.c_lt_n      = (child_idx < n_reg);
        sts.right_ok    = (right_idx < n_reg);
        sts.best_lt_key = (best_reg < key_reg);
        sts.newc_lt_n   = (newc_idx < n_reg);
        sts.out_free    = !mvalid_reg || m_tready;
        sts.out_last    = (({1'b0, o_reg} + CNT_W'(1)) == n_reg);
    end

    // store ports
    always_comb
    begin
        we    = 1'b0;
        waddr = p_reg;
        wdata = key_reg;
        if (cmd.load)
        begin
            we    = room;
            waddr = cnt_reg[ADDR_W-1:0];
            wdata = s_tdata;
        end
        else if (cmd.step_down)
        begin
            we    = 1'b1;
            wdata = best_reg;
        end
        else if (cmd.put_key)
        begin
            we = 1'b1;
        end

        raddr = '0;
        if (cmd.next_parent)
        begin
            raddr = i_reg - ADDR_W'(1);
        end
        else if (cmd.take_key)
        begin
            raddr = child_idx[ADDR_W-1:0];
        end
        else if (cmd.take_left)
        begin
            raddr = right_idx[ADDR_W-1:0];
        end
        else if (cmd.step_down)
        begin
            raddr = newc_idx[ADDR_W-1:0];
        end
        else if (cmd.out_read)
        begin
            raddr = o_reg;
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        o_next      = o_reg;
        mvalid_next = mvalid_reg;
        p_next      = p_reg;
        c_next      = c_reg;
        bc_next     = bc_reg;
        key_next    = key_reg;
        best_next   = best_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;

        if (cmd.load)
        begin
            cnt_next = cmd.start ? '0 : n_fill;
        end
        if (cmd.start)
        begin
            n_next = n_fill;
            i_next = n_fill[CNT_W-1:1];
        end
        if (cmd.next_parent)
        begin
            i_next = i_reg - ADDR_W'(1);
            p_next = i_reg - ADDR_W'(1);
        end
        if (cmd.take_key)
        begin
            key_next = rkey;
            c_next   = child_idx[ADDR_W-1:0];
        end
        if (cmd.take_left)
        begin
            best_next = rkey;
            bc_next   = c_reg;
        end
        // ties stay with the left child
        if (cmd.take_right && (rkey < best_reg))
        begin
            best_next = rkey;
            bc_next   = right_idx[ADDR_W-1:0];
        end
        if (cmd.step_down)
        begin
            p_next = bc_reg;
            c_next = newc_idx[ADDR_W-1:0];
        end
        if (cmd.out_clear)
        begin
            o_next = '0;
        end

        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            mvalid_next = 1'b1;
            mdata_next  = rdata;
            mlast_next  = sts.out_last;
            o_next      = o_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            o_reg      <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            o_reg      <= o_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        c_reg     <= c_next;
        bc_reg    <= bc_next;
        key_reg   <= key_next;
        best_reg  <= best_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

`default_nettype wire

// ----- hdl/min_heap_build.sv -----
// Top level of the bottom-up binary min heap builder.
//
// Signed 32-bit keys stream in on the slave side, one transaction per cycle in the load
// phase, and are stored in arrival order in a 64-entry single-port-read RAM; keys beyond 64
// are dropped. A transaction with tlast starts an in-place Floyd build: each parent from the
// last down to the root is sifted toward the smaller child (ties go left, a child moves up
// only when strictly smaller). The RAM's one registered read port sets the pace: a parent
// takes a parent read and a key capture, then per compare a left read, a right read when a
// right child exists and a compare/move step, plus a step to park the key when it sinks
// all the way to a leaf. The heap then leaves in index order on the master side, each
// result read from the RAM and then loaded into the output register, tlast on the final one.
// The last result sits in the output register while the next run is already being loaded.
`default_nettype none

module min_heap_build (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [mhb_pkg::KEY_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic                       s_tlast,   // last
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [mhb_pkg::KEY_W-1:0]  m_tdata,   // [31:0] value_res
    output logic                            m_tlast    // last_res
);

    import mhb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mhb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mhb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/mhb_chk.sv -----
// Port-level checker for the heap builder, bound to the top level.
`default_nettype none

module mhb_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // a pending result is not withdrawn
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its contents
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no input is taken while a run is still being read out
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during readout");

    // a closing transaction stops intake for the build
    a_build_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after last element");

endmodule

bind min_heap_build mhb_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
